// ===== rtl/vec3_operation_unit_macros.svh =====
// Assertion macros for the three-component vector ALU.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef VEC3_OPERATION_UNIT_MACROS_SVH
`define VEC3_OPERATION_UNIT_MACROS_SVH
`ifndef SYNTH
`define VOU_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vec3 operation unit assertion failed");
`define VOU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vec3 operation unit assertion failed");
`else
`define VOU_ASSERT(lbl, clk, rstn, ante, cons)
`define VOU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/vou_pkg.sv =====
// Shared constants, types and saturation helpers for the vector ALU.
// No dependencies; every other file but the macro header imports this package.
package vou_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int NUM_W      = DW + FRAC_BITS;
  localparam int PROD_W     = 2 * DW;
  localparam int LANE_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int RAD_W      = PROD_W;
  localparam int SIMPLE_W   = DW + 1;
  localparam int SQRT_STEPS = RAD_W / 2;

  typedef enum logic [3:0] {
    OP_NEG   = 4'd0,
    OP_SCALE = 4'd1,
    OP_DIV   = 4'd2,
    OP_SUB   = 4'd3,
    OP_ADD   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_LEN   = 4'd7,
    OP_LENSQ = 4'd8,
    OP_UNIT  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    FAULT_OK  = 2'd0,
    FAULT_DZ  = 2'd1,
    FAULT_SAT = 2'd2
  } fault_t;

  typedef struct packed {
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic signed [DW-1:0] rs;
    fault_t               fault;
  } res_t;

  typedef struct packed {
    op_t                  func;
    res_t                 res;
    logic [RAD_W-1:0]     rad;
    logic [2:0][DW-1:0]   amag;
    logic [2:0]           aneg;
    logic [DW-1:0]        smag;
    logic                 sneg;
    logic                 szero;
  } sq_t;

  typedef struct packed {
    op_t        func;
    res_t       res;
    logic [2:0] neg;
    logic       dz;
  } dv_t;

  localparam logic signed [SUM_W-1:0] WIDE_MAX =
    {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] WIDE_MIN =
    {{(SUM_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [NUM_W-1:0] QUOT_MAX = {{(NUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [NUM_W-1:0] QUOT_MIN = {{(NUM_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] INT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};

  // Returns the saturation flag above the clamped 32-bit value.
  function automatic logic [DW:0] sat_wide(input logic signed [SUM_W-1:0] v);
    if (v > WIDE_MAX) begin
      sat_wide = {1'b1, INT_MAX};
    end else if (v < WIDE_MIN) begin
      sat_wide = {1'b1, INT_MIN};
    end else begin
      sat_wide = {1'b0, v[DW-1:0]};
    end
  endfunction

  // Applies the sign to a quotient magnitude and clamps it.
  function automatic logic [DW:0] quot_sat(input logic [NUM_W-1:0] q, input logic neg);
    if (!neg) begin
      if (q > QUOT_MAX) quot_sat = {1'b1, INT_MAX};
      else quot_sat = {1'b0, q[DW-1:0]};
    end else begin
      if (q > QUOT_MIN) quot_sat = {1'b1, INT_MIN};
      else quot_sat = {1'b0, (~q[DW-1:0]) + DW'(1)};
    end
  endfunction

endpackage

// ===== rtl/vou_if.sv =====
// Valid/ready channel interfaces for operands and results.
// Depends on vou_pkg for the component width.
interface vou_in_if;
  import vou_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [3:0]           func;
  logic signed [DW-1:0] ax;
  logic signed [DW-1:0] ay;
  logic signed [DW-1:0] az;
  logic signed [DW-1:0] bx;
  logic signed [DW-1:0] by;
  logic signed [DW-1:0] bz;
  logic signed [DW-1:0] scalar;
  modport source(output valid, func, ax, ay, az, bx, by, bz, scalar, input ready);
  modport sink(input valid, func, ax, ay, az, bx, by, bz, scalar, output ready);
endinterface

interface vou_out_if;
  import vou_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] rx;
  logic signed [DW-1:0] ry;
  logic signed [DW-1:0] rz;
  logic signed [DW-1:0] rs;
  logic [1:0]           fault;
  modport source(output valid, rx, ry, rz, rs, fault, input ready);
  modport sink(input valid, rx, ry, rz, rs, fault, output ready);
endinterface

// ===== rtl/vou_mul_lane.sv =====
// One lane's pair of registered 32x32 signed multipliers.
// Depends on vou_pkg for widths.
module vou_mul_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [vou_pkg::DW-1:0] x0,
  input  logic signed [vou_pkg::DW-1:0] y0,
  input  logic signed [vou_pkg::DW-1:0] x1,
  input  logic signed [vou_pkg::DW-1:0] y1,
  output logic signed [vou_pkg::PROD_W-1:0] p0_r,
  output logic signed [vou_pkg::PROD_W-1:0] p1_r
);
  import vou_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= PROD_W'(x0) * PROD_W'(y0);
      p1_r <= PROD_W'(x1) * PROD_W'(y1);
    end
  end

endmodule

// ===== rtl/vou_merge.sv =====
// Merging stage: combines lane products, forms the simple results and
// saturates them in two registered steps. Depends on vou_pkg.
module vou_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_v,
  input  logic [3:0]                           func,
  input  logic [2:0][vou_pkg::DW-1:0]          a,
  input  logic [2:0][vou_pkg::DW-1:0]          b,
  input  logic [vou_pkg::DW-1:0]               s,
  input  logic [2:0][vou_pkg::PROD_W-1:0]      p0,
  input  logic [2:0][vou_pkg::PROD_W-1:0]      p1,
  output logic                                 out_v,
  output vou_pkg::sq_t                         out_pl
);
  import vou_pkg::*;

  logic                           va_r;
  logic [3:0]                     funca_r;
  logic [SUM_W-1:0]               suma_r;
  logic [2:0][LANE_W-1:0]         lanea_r;
  logic [2:0][SIMPLE_W-1:0]       simplea_r;
  logic [2:0][DW-1:0]             amag_r;
  logic [2:0]                     aneg_r;
  logic [DW-1:0]                  smag_r;
  logic                           sneg_r;
  logic                           szero_r;

  logic [SUM_W-1:0]               sum_c;
  logic [2:0][LANE_W-1:0]         lane_c;
  logic [2:0][SIMPLE_W-1:0]       simple_c;
  logic [2:0][DW-1:0]             amag_c;

  logic                           vb_r;
  sq_t                            pl_r;
  sq_t                            pl_c;
  logic [2:0][DW-1:0]             rv;
  logic [DW:0]                    t;
  logic                           sat;

  always_comb begin
    sum_c = SUM_W'($signed(p0[0])) + SUM_W'($signed(p0[1])) + SUM_W'($signed(p0[2]));
    for (int i = 0; i < 3; i++) begin
      lane_c[i] = LANE_W'($signed(p0[i])) - LANE_W'($signed(p1[i]));
      amag_c[i] = a[i][DW-1] ? DW'(0) - a[i] : a[i];
      case (op_t'(func))
        OP_NEG:  simple_c[i] = SIMPLE_W'(0) - SIMPLE_W'($signed(a[i]));
        OP_ADD:  simple_c[i] = SIMPLE_W'($signed(a[i])) + SIMPLE_W'($signed(b[i]));
        OP_SUB:  simple_c[i] = SIMPLE_W'($signed(a[i])) - SIMPLE_W'($signed(b[i]));
        default: simple_c[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      funca_r   <= func;
      suma_r    <= sum_c;
      lanea_r   <= lane_c;
      simplea_r <= simple_c;
      amag_r    <= amag_c;
      for (int i = 0; i < 3; i++) aneg_r[i] <= a[i][DW-1];
      smag_r    <= s[DW-1] ? DW'(0) - s : s;
      sneg_r    <= s[DW-1];
      szero_r   <= (s == '0);
    end
  end

  always_comb begin
    rv  = '0;
    sat = 1'b0;
    t   = '0;
    pl_c = '0;
    pl_c.func  = op_t'(funca_r);
    pl_c.rad   = suma_r[RAD_W-1:0];
    pl_c.amag  = amag_r;
    pl_c.aneg  = aneg_r;
    pl_c.smag  = smag_r;
    pl_c.sneg  = sneg_r;
    pl_c.szero = szero_r;
    case (op_t'(funca_r))
      OP_NEG, OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          t     = sat_wide(SUM_W'($signed(simplea_r[i])));
          rv[i] = t[DW-1:0];
          sat   = sat | t[DW];
        end
      end
      OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t     = sat_wide(SUM_W'($signed(lanea_r[i]) >>> FRAC_BITS));
          rv[i] = t[DW-1:0];
          sat   = sat | t[DW];
        end
      end
      OP_DOT, OP_LENSQ: begin
        t = sat_wide($signed(suma_r) >>> FRAC_BITS);
        pl_c.res.rs = t[DW-1:0];
        sat = t[DW];
      end
      default: begin
      end
    endcase
    pl_c.res.rx    = rv[0];
    pl_c.res.ry    = rv[1];
    pl_c.res.rz    = rv[2];
    pl_c.res.fault = sat ? FAULT_SAT : FAULT_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_c;
    end
  end

  assign out_v  = vb_r;
  assign out_pl = pl_r;

endmodule

// ===== rtl/vou_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, carrying the
// item's payload alongside. Depends on vou_pkg.
module vou_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  vou_pkg::sq_t            in_pl,
  output logic                    out_v,
  output vou_pkg::sq_t            out_pl,
  output logic [vou_pkg::DW-1:0]  out_root
);
  import vou_pkg::*;

  logic [SQRT_STEPS-1:0] v_r;
  sq_t                   pl_r   [SQRT_STEPS];
  logic [RAD_W-1:0]      rem_r  [SQRT_STEPS];
  logic [RAD_W-1:0]      root_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic             src_v;
    sq_t              src_pl;
    logic [RAD_W-1:0] src_rem;
    logic [RAD_W-1:0] src_root;
    logic [RAD_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_v    = in_v;
      assign src_pl   = in_pl;
      assign src_rem  = in_pl.rad;
      assign src_root = '0;
    end else begin : g_next
      assign src_v    = v_r[k-1];
      assign src_pl   = pl_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
    end

    assign trial = src_root + BIT;
    assign ge    = (src_rem >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[k]   <= src_pl;
        rem_r[k]  <= ge ? src_rem - trial : src_rem;
        root_r[k] <= ge ? (src_root >> 1) + BIT : src_root >> 1;
      end
    end
  end

  assign out_v    = v_r[SQRT_STEPS-1];
  assign out_pl   = pl_r[SQRT_STEPS-1];
  assign out_root = root_r[SQRT_STEPS-1][DW-1:0];

endmodule

// ===== rtl/vou_div_lane.sv =====
// One lane of pipelined restoring division: (num << FRAC_BITS) / den,
// one quotient bit per stage. Depends on vou_pkg.
module vou_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vou_pkg::DW-1:0]     num,
  input  logic [vou_pkg::DW-1:0]     den,
  output logic [vou_pkg::NUM_W-1:0]  quot
);
  import vou_pkg::*;

  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DW-1:0]    rem_r [NUM_W-1];
  logic [DW-1:0]    den_r [NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] src_nq;
    logic [DW-1:0]    src_rem;
    logic [DW-1:0]    src_den;
    logic [DW:0]      t;
    logic [DW:0]      diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_nq  = {num, {FRAC_BITS{1'b0}}};
      assign src_rem = '0;
      assign src_den = den;
    end else begin : g_next
      assign src_nq  = nq_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_den = den_r[k-1];
    end

    assign t    = {src_rem, src_nq[NUM_W-1]};
    assign diff = t - {1'b0, src_den};
    assign ge   = (t >= {1'b0, src_den});

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k] <= {src_nq[NUM_W-2:0], ge};
      end
    end

    if (k < NUM_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
          den_r[k] <= src_den;
        end
      end
    end
  end

  assign quot = nq_r[NUM_W-1];

endmodule

// ===== rtl/vec3_operation_unit.sv =====
// Three-component vector ALU top level: input register, three multiplier
// lanes, merge stage, square root pipeline, three divider lanes, output
// register with skid stage. Uses vou_pkg, vou_if and the macro header.
// Data is Q16.16; the path runs through the 32-step root pipeline and then the
// 32 + FRAC_BITS pipelined divider stages.
// One transaction per cycle while the skid stage is empty; synchronous active-low reset clears valid bits.
`include "vec3_operation_unit_macros.svh"
module vec3_operation_unit (
  input logic       clk,
  input logic       rst_n,
  vou_in_if.sink    in_ch,
  vou_out_if.source out_ch
);
  import vou_pkg::*;

  logic en;

  logic               v0_r;
  logic [3:0]         func0_r;
  logic [2:0][DW-1:0] a0_r;
  logic [2:0][DW-1:0] b0_r;
  logic [DW-1:0]      s0_r;

  logic               v1_r;
  logic [3:0]         func1_r;
  logic [2:0][DW-1:0] a1_r;
  logic [2:0][DW-1:0] b1_r;
  logic [DW-1:0]      s1_r;

  logic [2:0][PROD_W-1:0] p0;
  logic [2:0][PROD_W-1:0] p1;

  logic        mv;
  sq_t         mpl;
  logic        qv;
  sq_t         qpl;
  logic [DW-1:0] root;

  dv_t           dprep;
  logic [DW-1:0] den;
  logic [2:0][NUM_W-1:0] quot;
  logic [NUM_W-1:0] dvv_r;
  dv_t              dv_r [NUM_W];

  res_t fin_c;
  res_t fin_r;
  logic fin_v_r;
  res_t out_r;
  logic out_v_r;
  res_t skid_r;
  logic skid_v_r;
  logic out_take;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func0_r <= in_ch.func;
      a0_r    <= {in_ch.az, in_ch.ay, in_ch.ax};
      b0_r    <= {in_ch.bz, in_ch.by, in_ch.bx};
      s0_r    <= in_ch.scalar;
      func1_r <= func0_r;
      a1_r    <= a0_r;
      b1_r    <= b0_r;
      s1_r    <= s0_r;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    localparam int J = (g + 1) % 3;
    localparam int K = (g + 2) % 3;
    logic signed [DW-1:0] x0, y0, x1, y1;

    always_comb begin
      x0 = '0;
      y0 = '0;
      x1 = '0;
      y1 = '0;
      case (op_t'(func0_r))
        OP_SCALE: begin
          x0 = a0_r[g];
          y0 = s0_r;
        end
        OP_DOT: begin
          x0 = a0_r[g];
          y0 = b0_r[g];
        end
        OP_CROSS: begin
          x0 = a0_r[J];
          y0 = b0_r[K];
          x1 = a0_r[K];
          y1 = b0_r[J];
        end
        OP_LEN, OP_LENSQ, OP_UNIT: begin
          x0 = a0_r[g];
          y0 = a0_r[g];
        end
        default: begin
        end
      endcase
    end

    vou_mul_lane u_mul (
      .clk  (clk),
      .en   (en),
      .x0   (x0),
      .y0   (y0),
      .x1   (x1),
      .y1   (y1),
      .p0_r (p0[g]),
      .p1_r (p1[g])
    );

    vou_div_lane u_div (
      .clk  (clk),
      .en   (en),
      .num  (qpl.amag[g]),
      .den  (den),
      .quot (quot[g])
    );
  end

  vou_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (v1_r),
    .func   (func1_r),
    .a      (a1_r),
    .b      (b1_r),
    .s      (s1_r),
    .p0     (p0),
    .p1     (p1),
    .out_v  (mv),
    .out_pl (mpl)
  );

  vou_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (mv),
    .in_pl    (mpl),
    .out_v    (qv),
    .out_pl   (qpl),
    .out_root (root)
  );

  always_comb begin
    dprep.func = qpl.func;
    dprep.res  = qpl.res;
    for (int i = 0; i < 3; i++) begin
      dprep.neg[i] = (qpl.func == OP_DIV) ? (qpl.aneg[i] ^ qpl.sneg) : qpl.aneg[i];
    end
    dprep.dz = ((qpl.func == OP_DIV) && qpl.szero) || ((qpl.func == OP_UNIT) && (root == '0));
    if (qpl.func == OP_LEN) begin
      if (root[DW-1]) begin
        dprep.res.rs    = INT_MAX;
        dprep.res.fault = FAULT_SAT;
      end else begin
        dprep.res.rs    = root;
        dprep.res.fault = FAULT_OK;
      end
    end
    den = (qpl.func == OP_DIV) ? qpl.smag : root;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k] <= 1'b0;
      end else if (en) begin
        dvv_r[k] <= (k == 0) ? qv : dvv_r[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= (k == 0) ? dprep : dv_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_comb begin
    logic [2:0][DW-1:0] rv;
    logic [DW:0]        t;
    logic               sat;
    rv    = '0;
    t     = '0;
    sat   = 1'b0;
    fin_c = dv_r[NUM_W-1].res;
    if ((dv_r[NUM_W-1].func == OP_DIV) || (dv_r[NUM_W-1].func == OP_UNIT)) begin
      if (dv_r[NUM_W-1].dz) begin
        fin_c       = '0;
        fin_c.fault = FAULT_DZ;
      end else begin
        for (int i = 0; i < 3; i++) begin
          t     = quot_sat(quot[i], dv_r[NUM_W-1].neg[i]);
          rv[i] = t[DW-1:0];
          sat   = sat | t[DW];
        end
        fin_c.rx    = rv[0];
        fin_c.ry    = rv[1];
        fin_c.rz    = rv[2];
        fin_c.rs    = '0;
        fin_c.fault = sat ? FAULT_SAT : FAULT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dvv_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_c;
    end
  end

  assign out_take = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_take || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= fin_v_r;
      end
    end else if (fin_v_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : fin_r;
    end else if (fin_v_r && en) begin
      skid_r <= fin_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.rx    = out_r.rx;
  assign out_ch.ry    = out_r.ry;
  assign out_ch.rz    = out_r.rz;
  assign out_ch.rs    = out_r.rs;
  assign out_ch.fault = out_r.fault;

  `VOU_ASSERT(a_skid_implies_out, clk, rst_n, skid_v_r, out_v_r)
  `VOU_ASSERT(a_skid_fill_on_stall, clk, rst_n, $rose(skid_v_r), $past(out_v_r && !out_ch.ready))
  `VOU_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_v_r && !out_ch.ready, skid_v_r)
  `VOU_ASSERT(a_dz_zero, clk, rst_n, out_v_r && (out_r.fault == FAULT_DZ), (out_r.rx == '0) && (out_r.ry == '0) && (out_r.rz == '0) && (out_r.rs == '0))

endmodule
